// ===== hw/rtl/jpeg_icc_segment_extractor_assert.svh =====
// Assertion macros shared by the checker of the ICC segment extractor
`ifndef JPEG_ICC_SEGMENT_EXTRACTOR_ASSERT_SVH
`define JPEG_ICC_SEGMENT_EXTRACTOR_ASSERT_SVH
// same-cycle implication
`define JICS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("jics: implication failed");
// next-cycle implication
`define JICS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("jics: next-cycle implication failed");
`endif

// ===== hw/rtl/jics_pkg.sv =====
// Types, constants and helpers of the JPEG ICC segment extractor
`timescale 1ns / 1ps
package jics_pkg;
  localparam int MAX_PIECES_DEF = 256;
  localparam int QDEPTH = 4;
  localparam logic [24:0] MAX_BYTES_RST = 25'h1000000;

  localparam logic [7:0] B_FF = 8'hff;
  localparam logic [7:0] B_SOI = 8'hd8;
  localparam logic [7:0] B_EOI = 8'hd9;
  localparam logic [7:0] B_SOS = 8'hda;
  localparam logic [7:0] B_TEM = 8'h01;
  localparam logic [7:0] B_RST0 = 8'hd0;
  localparam logic [7:0] B_RST7 = 8'hd7;
  localparam logic [7:0] B_APP2 = 8'he2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_NOT_JPEG = 3'd0;
  localparam logic [2:0] ST_NO_ICC = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_COMPLETE = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;

  typedef enum logic [6:0] {
    PH_START1 = 7'b0000001,
    PH_START2 = 7'b0000010,
    PH_SCAN   = 7'b0000100,
    PH_MARK   = 7'b0001000,
    PH_LEN_HI = 7'b0010000,
    PH_LEN_LO = 7'b0100000,
    PH_BODY   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [7:0]  seq;
    logic [7:0]  cnt;
    logic [2:0]  status;
    logic        adv;
    logic [23:0] len;
    logic        trunc;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic [1:0] n;
    entry_t     e0;
    entry_t     e1;
  } push_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] i);
    case (i)
      4'd0: sig_byte = 8'h49;
      4'd1: sig_byte = 8'h43;
      4'd2: sig_byte = 8'h43;
      4'd3: sig_byte = 8'h5f;
      4'd4: sig_byte = 8'h50;
      4'd5: sig_byte = 8'h52;
      4'd6: sig_byte = 8'h4f;
      4'd7: sig_byte = 8'h46;
      4'd8: sig_byte = 8'h49;
      4'd9: sig_byte = 8'h4c;
      4'd10: sig_byte = 8'h45;
      default: sig_byte = 8'h00;
    endcase
  endfunction
endpackage

// ===== hw/rtl/jics_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module jics_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end
endmodule

// ===== hw/rtl/jics_front.sv =====
// Byte parser: marker scan, segment walk, ICC piece tracking and result build
`timescale 1ns / 1ps
module jics_front #(
  parameter int MAX_PIECES = jics_pkg::MAX_PIECES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                cfg_wr_en,
  input  logic [24:0]         cfg_wr_data,
  output jics_pkg::push_t     push
);
  localparam int IW = $clog2(MAX_PIECES);

  jics_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic        sig_r, sig_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [7:0]  exp_r, exp_nxt;
  logic [MAX_PIECES-1:0] seen_r, seen_nxt;
  logic [8:0]  dist_r, dist_nxt;
  logic [24:0] tot_r, tot_nxt;
  logic        adv_r, adv_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  bs_r, bs_nxt;
  logic        pacc_r, pacc_nxt;
  logic [24:0] max_r;

  logic        acc, stop, emit, stat, trunc, commit, rd_en;
  logic [15:0] seg, rd_data;
  logic [24:0] old_len;
  logic [IW-1:0] idx;
  logic [2:0]  st;
  jics_pkg::entry_t pay_e, st_e;

  assign acc = in_valid & in_ready;
  assign idx = seq_r[IW-1:0];

  jics_ram #(.WIDTH(16), .DEPTH(MAX_PIECES)) u_len_ram (
    .clk(clk), .wr_en(commit), .wr_addr(idx), .wr_data(plen_r),
    .rd_en(rd_en), .rd_addr(data_byte[IW-1:0]), .rd_data_r(rd_data)
  );

  always_comb begin
    phase_nxt = phase_r; rem_nxt = rem_r; marker_nxt = marker_r;
    hidx_nxt = hidx_r; sig_nxt = sig_r; seq_nxt = seq_r; cnt_nxt = cnt_r;
    plen_nxt = plen_r; exp_nxt = exp_r; seen_nxt = seen_r; dist_nxt = dist_r;
    tot_nxt = tot_r; adv_nxt = adv_r; fin_nxt = fin_r; bs_nxt = bs_r;
    pacc_nxt = pacc_r;
    stop = 1'b0; emit = 1'b0; stat = 1'b0; trunc = 1'b0; commit = 1'b0;
    rd_en = 1'b0; old_len = '0; st = jics_pkg::ST_NOT_JPEG;
    seg = {rem_r[15:8], data_byte};
    if (acc && !fin_r) begin
      if (bs_r < 3'd4) begin
        bs_nxt = bs_r + 3'd1;
      end
      case (phase_r)
        jics_pkg::PH_START1: begin
          if (data_byte == jics_pkg::B_FF) phase_nxt = jics_pkg::PH_START2;
          else stop = 1'b1;
        end
        jics_pkg::PH_START2: begin
          if (data_byte == jics_pkg::B_SOI) phase_nxt = jics_pkg::PH_SCAN;
          else stop = 1'b1;
        end
        jics_pkg::PH_SCAN: begin
          if (data_byte == jics_pkg::B_FF) phase_nxt = jics_pkg::PH_MARK;
        end
        jics_pkg::PH_MARK: begin
          if (data_byte == jics_pkg::B_FF) begin
            phase_nxt = jics_pkg::PH_MARK;
          end else if (data_byte == jics_pkg::B_EOI || data_byte == jics_pkg::B_SOS) begin
            stop = 1'b1;
          end else if (data_byte == jics_pkg::B_TEM ||
                       (data_byte >= jics_pkg::B_RST0 && data_byte <= jics_pkg::B_RST7)) begin
            phase_nxt = jics_pkg::PH_SCAN;
          end else begin
            marker_nxt = data_byte;
            phase_nxt = jics_pkg::PH_LEN_HI;
          end
        end
        jics_pkg::PH_LEN_HI: begin
          rem_nxt = {data_byte, 8'h00};
          phase_nxt = jics_pkg::PH_LEN_LO;
        end
        jics_pkg::PH_LEN_LO: begin
          if (seg < 16'd2) begin
            stop = 1'b1;
          end else begin
            rem_nxt = seg - 16'd2;
            hidx_nxt = '0;
            pacc_nxt = 1'b0;
            sig_nxt = (marker_r == jics_pkg::B_APP2) && (rem_nxt >= 16'd14);
            plen_nxt = sig_nxt ? rem_nxt - 16'd14 : 16'd0;
            phase_nxt = (rem_nxt == 16'd0) ? jics_pkg::PH_SCAN : jics_pkg::PH_BODY;
          end
        end
        jics_pkg::PH_BODY: begin
          rem_nxt = rem_r - 16'd1;
          if (hidx_r < 4'd12) begin
            if (data_byte != jics_pkg::sig_byte(hidx_r)) sig_nxt = 1'b0;
            hidx_nxt = hidx_r + 4'd1;
          end else if (hidx_r == 4'd12) begin
            seq_nxt = data_byte;
            hidx_nxt = 4'd13;
            rd_en = 1'b1;  // fetch the old length of this sequence early
          end else if (hidx_r == 4'd13) begin
            cnt_nxt = data_byte;
            hidx_nxt = 4'd14;
            pacc_nxt = sig_r && (seq_r != 8'd0) && (data_byte != 8'd0) &&
                       (seq_r <= data_byte) && ({1'b0, data_byte} < 9'(MAX_PIECES)) &&
                       ((exp_r == 8'd0) || (exp_r == data_byte));
          end else if (pacc_r) begin
            emit = 1'b1;
          end
          if (rem_nxt == 16'd0) begin
            if (sig_nxt && hidx_nxt >= 4'd14) adv_nxt = 1'b1;
            if (pacc_nxt) begin
              commit = 1'b1;
              old_len = seen_r[idx] ? {9'd0, rd_data} : 25'd0;
              tot_nxt = tot_r - old_len + {9'd0, plen_r};
              if (!seen_r[idx]) dist_nxt = dist_r + 9'd1;
              seen_nxt[idx] = 1'b1;
              exp_nxt = cnt_nxt;
            end
            pacc_nxt = 1'b0;
            phase_nxt = jics_pkg::PH_SCAN;
          end
        end
        default: phase_nxt = jics_pkg::PH_START1;
      endcase
      stat = stop | last_byte;
      trunc = !stop && (phase_nxt == jics_pkg::PH_LEN_HI ||
                        phase_nxt == jics_pkg::PH_LEN_LO || phase_nxt == jics_pkg::PH_BODY);
      if (stop) fin_nxt = 1'b1;
      if (bs_nxt < 3'd4) st = jics_pkg::ST_NOT_JPEG;
      else if (adv_nxt && exp_nxt != 8'd0 && {1'b0, exp_nxt} == dist_nxt)
        st = (tot_nxt > max_r) ? jics_pkg::ST_TOO_LARGE : jics_pkg::ST_COMPLETE;
      else st = adv_nxt ? jics_pkg::ST_INCOMPLETE : jics_pkg::ST_NO_ICC;
    end
    pay_e = '{kind: jics_pkg::KIND_PAYLOAD, payload: data_byte, seq: seq_r, cnt: cnt_r,
              status: 3'd0, adv: 1'b0, len: 24'd0, trunc: 1'b0, last: 1'b0};
    st_e = '{kind: jics_pkg::KIND_STATUS, payload: 8'd0, seq: 8'd0, cnt: 8'd0,
             status: st, adv: adv_nxt, len: tot_nxt[24] ? 24'hffffff : tot_nxt[23:0],
             trunc: trunc, last: 1'b1};
    // new file after the final byte
    if (acc && last_byte) begin
      phase_nxt = jics_pkg::PH_START1; rem_nxt = '0; marker_nxt = '0; hidx_nxt = '0;
      sig_nxt = 1'b0; seq_nxt = '0; cnt_nxt = '0; plen_nxt = '0; exp_nxt = '0;
      seen_nxt = '0; dist_nxt = '0; tot_nxt = '0; adv_nxt = 1'b0; fin_nxt = 1'b0;
      bs_nxt = '0; pacc_nxt = 1'b0;
    end
  end

  always_comb begin
    push.n = {1'b0, emit} + {1'b0, stat};
    push.e0 = emit ? pay_e : st_e;
    push.e1 = st_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jics_pkg::PH_START1; rem_r <= '0; marker_r <= '0; hidx_r <= '0;
      sig_r <= 1'b0; seq_r <= '0; cnt_r <= '0; plen_r <= '0; exp_r <= '0;
      seen_r <= '0; dist_r <= '0; tot_r <= '0; adv_r <= 1'b0; fin_r <= 1'b0;
      bs_r <= '0; pacc_r <= 1'b0; max_r <= jics_pkg::MAX_BYTES_RST;
    end else begin
      phase_r <= phase_nxt; rem_r <= rem_nxt; marker_r <= marker_nxt;
      hidx_r <= hidx_nxt; sig_r <= sig_nxt; seq_r <= seq_nxt; cnt_r <= cnt_nxt;
      plen_r <= plen_nxt; exp_r <= exp_nxt; seen_r <= seen_nxt; dist_r <= dist_nxt;
      tot_r <= tot_nxt; adv_r <= adv_nxt; fin_r <= fin_nxt; bs_r <= bs_nxt;
      pacc_r <= pacc_nxt;
      if (cfg_wr_en) max_r <= cfg_wr_data;
    end
  end
endmodule

// ===== hw/rtl/jics_queue.sv =====
// Result queue between parser and output: up to two pushes and up to one pop per cycle
`timescale 1ns / 1ps
module jics_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  jics_pkg::push_t  push,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output jics_pkg::entry_t head
);
  localparam int PW = $clog2(jics_pkg::QDEPTH);
  localparam int CW = $clog2(jics_pkg::QDEPTH + 1);

  jics_pkg::entry_t q_r [jics_pkg::QDEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt, wptr1;
  logic [CW-1:0] count_r, count_nxt;
  logic pop;

  assign pop = out_valid & out_ready;
  assign out_valid = (count_r != '0);
  assign head = q_r[rptr_r];
  // room for two beats keeps a byte that yields two results from stalling
  assign space_ok = (count_r <= CW'(jics_pkg::QDEPTH - 2));
  assign wptr1 = wptr_r + PW'(1);

  always_comb begin
    wptr_nxt = wptr_r + PW'(push.n);
    rptr_nxt = pop ? rptr_r + PW'(1) : rptr_r;
    count_nxt = count_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wptr_r] <= push.e0;
    if (push.n == 2'd2) q_r[wptr1] <= push.e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0; rptr_r <= '0; count_r <= '0;
    end else begin
      wptr_r <= wptr_nxt; rptr_r <= rptr_nxt; count_r <= count_nxt;
    end
  end
endmodule

// ===== hw/rtl/jpeg_icc_segment_extractor.sv =====
// A byte's results go into a four-entry result queue when it is taken.
// Throughput: one byte per cycle while the queue has room for two beats; a
// payload plus status gives two beats, drained one per cycle on out_tready.
// Reset (rst_n low, synchronous) returns the parser to the file start and
// empties the queue; max_profile_bytes returns to 16777216.
`timescale 1ns / 1ps
module jpeg_icc_segment_extractor #(
  parameter int MAX_PIECES = jics_pkg::MAX_PIECES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // payload_byte, piece_sequence, piece_count, status, advertised,
  // profile_length, truncated, zero fill
  output logic [55:0] out_tdata,
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic [24:0] cfg_wr_data
);
  jics_pkg::push_t  push;
  jics_pkg::entry_t head;

  jics_front #(.MAX_PIECES(MAX_PIECES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .data_byte(in_tdata), .last_byte(in_tlast), .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data), .push(push)
  );

  jics_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .space_ok(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .head(head)
  );

  assign out_tdata = {3'd0, head.trunc, head.len, head.adv, head.status,
                      head.cnt, head.seq, head.payload};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;
endmodule

// ===== hw/rtl/jics_checker.sv =====
// Port-level checker of the ICC segment extractor, bound to the top level
`timescale 1ns / 1ps
`include "jpeg_icc_segment_extractor_assert.svh"
module jics_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);
  `JICS_ASSERT_IMP(a_last_is_status, clk, rst_n, out_tvalid, out_tlast == out_tuser)
  `JICS_ASSERT_IMP(a_payload_clean, clk, rst_n, out_tvalid && !out_tuser, out_tdata[55:24] == '0)
  `JICS_ASSERT_IMP(a_status_clean, clk, rst_n, out_tvalid && out_tuser, out_tdata[23:0] == '0 && out_tdata[26:24] <= 3'd4)
  `JICS_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind jpeg_icc_segment_extractor jics_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);
